// ===== rtl/bmhq_pkg.sv =====
// Types and codes shared by the binary min-heap priority queue.
package bmhq_pkg;

   localparam int KEY_W        = 32;
   localparam int PAYLOAD_W    = 32;
   localparam int ITEM_COUNT_W = 7;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      req_kind_type                 req_type;
      logic signed [KEY_W-1:0]      item_key;
      logic        [PAYLOAD_W-1:0]  item_payload;
   } req_item_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]      out_key;
      logic        [PAYLOAD_W-1:0]  out_payload;
      logic        [ITEM_COUNT_W-1:0] item_count;
      status_type                   status;
   } rsp_item_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]      key;
      logic        [PAYLOAD_W-1:0]  payload;
   } entry_type;

endpackage

// ===== rtl/binary_min_heap_queue_top.sv =====
// Binary min-heap priority queue with a single-port-read heap memory and a sift sequencer.
//
// Pulse start while busy is low to transfer one request: insert (key, payload) or remove
// the minimum. Exactly one result follows, on rsp_data for the single cycle that rsp_valid
// is high; the receiver cannot stall it. An insert compares the item with each parent on the
// way up until it settles or reaches the root; a full insert only reads back the root. A
// remove reads the last item into the root and walks it down, reading both children of a
// node that has two, the one child of a node with a single child and none of a leaf;
// removing the only item or removing from an empty heap needs no walk. The sequencing is
// set by the heap memory, which gives one registered read per cycle, and by the one shared
// key comparator used at every level.
// After an insert the result carries the current minimum; after a remove, the removed item.
// Ties never move an item past an equal key, and a left child wins over an equal right one.
module binary_min_heap_queue_top #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bmhq_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output bmhq_pkg::rsp_item_type rsp_data
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int NW = AW + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_FIN_RD,
      ST_FIN_OUT,
      ST_RM_ROOT,
      ST_RM_LAST,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMPR
   } state_type;

   state_type               state_ff;
   logic [CW-1:0]           count_ff;
   logic [AW-1:0]           pos_ff;
   bmhq_pkg::entry_type     cur_ff;
   bmhq_pkg::entry_type     best_ff;
   logic                    best_left_ff;
   logic                    rsp_valid_ff;
   bmhq_pkg::rsp_item_type  rsp_data_ff;

   bmhq_pkg::entry_type     heap_mem [HEAP_DEPTH];
   bmhq_pkg::entry_type     rd_data_ff;

   logic                    rd_en_in;
   logic [AW-1:0]           rd_addr_in;
   logic                    wr_en_in;
   logic [AW-1:0]           wr_addr_in;
   bmhq_pkg::entry_type     wr_data_in;

   logic signed [bmhq_pkg::KEY_W-1:0] cmp_a;
   logic signed [bmhq_pkg::KEY_W-1:0] cmp_b;
   logic                    cmp_lt;

   logic [AW-1:0]           pos_m1;
   logic [AW-1:0]           parent_idx;
   logic [NW-1:0]           left_idx;
   logic [NW-1:0]           right_idx;
   logic [NW-1:0]           count_ext;
   logic [CW-1:0]           count_m1;
   logic [AW-1:0]           last_idx;
   logic                    heap_full;
   logic [CW+bmhq_pkg::ITEM_COUNT_W-1:0] count_wide;
   logic [bmhq_pkg::ITEM_COUNT_W-1:0]    count_out;

   // Heap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         heap_mem[wr_addr_in] <= wr_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en_in) begin
         rd_data_ff <= heap_mem[rd_addr_in];
      end
   end

   // Shared signed key comparator: cmp_lt = a < b.
   always_comb begin
      cmp_a = cur_ff.key;
      cmp_b = rd_data_ff.key;
      unique case (state_ff)
         ST_DN_RDR: begin
            cmp_a = rd_data_ff.key;
            cmp_b = cur_ff.key;
         end
         ST_DN_CMPR: begin
            cmp_a = rd_data_ff.key;
            cmp_b = best_ff.key;
         end
         default: begin
            cmp_a = cur_ff.key;
            cmp_b = rd_data_ff.key;
         end
      endcase
      cmp_lt = (cmp_a < cmp_b);
   end

   always_comb begin
      pos_m1     = pos_ff - AW'(1);
      parent_idx = pos_m1 >> 1;
      left_idx   = {1'b0, pos_ff, 1'b1};
      right_idx  = left_idx + NW'(1);
      count_ext  = NW'(count_ff);
      count_m1   = count_ff - CW'(1);
      last_idx   = count_m1[AW-1:0];
      heap_full  = (count_ff == CW'(HEAP_DEPTH));
      count_wide = {{bmhq_pkg::ITEM_COUNT_W{1'b0}}, count_ff};
      count_out  = count_wide[bmhq_pkg::ITEM_COUNT_W-1:0];
   end

   // Memory port control; the moving item stays in cur_ff and the hole walks.
   always_comb begin
      rd_en_in   = 1'b0;
      rd_addr_in = '0;
      wr_en_in   = 1'b0;
      wr_addr_in = pos_ff;
      wr_data_in = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_data.req_type == bmhq_pkg::REQ_REMOVE) && (count_ff != '0)) begin
               rd_en_in = 1'b1;
            end
         end
         ST_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en_in = 1'b1;
            end else begin
               rd_en_in   = 1'b1;
               rd_addr_in = parent_idx;
            end
         end
         ST_UP_CMP: begin
            wr_en_in   = 1'b1;
            wr_data_in = cmp_lt ? rd_data_ff : cur_ff;
         end
         ST_FIN_RD: begin
            rd_en_in = 1'b1;
         end
         ST_RM_ROOT: begin
            if (count_m1 != '0) begin
               rd_en_in   = 1'b1;
               rd_addr_in = last_idx;
            end
         end
         ST_DN_RDL: begin
            if (left_idx >= count_ext) begin
               wr_en_in = 1'b1;
            end else begin
               rd_en_in   = 1'b1;
               rd_addr_in = left_idx[AW-1:0];
            end
         end
         ST_DN_RDR: begin
            if (right_idx < count_ext) begin
               rd_en_in   = 1'b1;
               rd_addr_in = right_idx[AW-1:0];
            end else begin
               wr_en_in   = 1'b1;
               wr_data_in = cmp_lt ? rd_data_ff : cur_ff;
            end
         end
         ST_DN_CMPR: begin
            wr_en_in   = 1'b1;
            wr_data_in = cmp_lt ? rd_data_ff : best_ff;
         end
         default: begin
            rd_en_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (req_data.req_type == bmhq_pkg::REQ_INSERT) begin
                     if (heap_full) begin
                        rsp_data_ff.status <= bmhq_pkg::STATUS_FULL;
                        state_ff           <= ST_FIN_RD;
                     end else begin
                        cur_ff.key         <= req_data.item_key;
                        cur_ff.payload     <= req_data.item_payload;
                        pos_ff             <= count_ff[AW-1:0];
                        rsp_data_ff.status <= bmhq_pkg::STATUS_OK;
                        state_ff           <= ST_UP_CHK;
                     end
                  end else if (count_ff == '0) begin
                     rsp_data_ff.out_key     <= '0;
                     rsp_data_ff.out_payload <= '0;
                     rsp_data_ff.item_count  <= '0;
                     rsp_data_ff.status      <= bmhq_pkg::STATUS_EMPTY;
                     rsp_valid_ff            <= 1'b1;
                  end else begin
                     rsp_data_ff.status <= bmhq_pkg::STATUS_OK;
                     state_ff           <= ST_RM_ROOT;
                  end
               end
            end
            ST_UP_CHK: begin
               if (pos_ff == '0) begin
                  count_ff <= count_ff + CW'(1);
                  state_ff <= ST_FIN_RD;
               end else begin
                  state_ff <= ST_UP_CMP;
               end
            end
            ST_UP_CMP: begin
               if (cmp_lt) begin
                  pos_ff   <= parent_idx;
                  state_ff <= ST_UP_CHK;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  state_ff <= ST_FIN_RD;
               end
            end
            ST_FIN_RD: begin
               state_ff <= ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
               rsp_data_ff.out_key     <= rd_data_ff.key;
               rsp_data_ff.out_payload <= rd_data_ff.payload;
               rsp_data_ff.item_count  <= count_out;
               rsp_valid_ff            <= 1'b1;
               state_ff                <= ST_IDLE;
            end
            ST_RM_ROOT: begin
               rsp_data_ff.out_key     <= rd_data_ff.key;
               rsp_data_ff.out_payload <= rd_data_ff.payload;
               count_ff                <= count_m1;
               if (count_m1 == '0) begin
                  rsp_data_ff.item_count <= '0;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= ST_IDLE;
               end else begin
                  state_ff <= ST_RM_LAST;
               end
            end
            ST_RM_LAST: begin
               cur_ff   <= rd_data_ff;
               pos_ff   <= '0;
               state_ff <= ST_DN_RDL;
            end
            ST_DN_RDL: begin
               if (left_idx >= count_ext) begin
                  rsp_data_ff.item_count <= count_out;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= ST_IDLE;
               end else begin
                  state_ff <= ST_DN_RDR;
               end
            end
            ST_DN_RDR: begin
               best_ff      <= cmp_lt ? rd_data_ff : cur_ff;
               best_left_ff <= cmp_lt;
               if (right_idx < count_ext) begin
                  state_ff <= ST_DN_CMPR;
               end else if (cmp_lt) begin
                  pos_ff   <= left_idx[AW-1:0];
                  state_ff <= ST_DN_RDL;
               end else begin
                  rsp_data_ff.item_count <= count_out;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= ST_IDLE;
               end
            end
            ST_DN_CMPR: begin
               if (cmp_lt) begin
                  pos_ff   <= right_idx[AW-1:0];
                  state_ff <= ST_DN_RDL;
               end else if (best_left_ff) begin
                  pos_ff   <= left_idx[AW-1:0];
                  state_ff <= ST_DN_RDL;
               end else begin
                  rsp_data_ff.item_count <= count_out;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer active");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("fill count beyond heap depth");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == bmhq_pkg::STATUS_FULL)) |-> heap_full)
      else $error("full status with room left");

   a_empty_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == bmhq_pkg::STATUS_EMPTY)) |->
         ((count_ff == '0) && (rsp_data.item_count == '0)))
      else $error("empty status with items held");
`endif

endmodule

// ===== test/heap_order_checker.sv =====
// Checker for the min-heap queue: predicts every result from accepted requests and compares.
`timescale 1ns / 100ps

module heap_order_checker #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  bmhq_pkg::req_item_type req_data,
   input  logic                   rsp_valid,
   input  bmhq_pkg::rsp_item_type rsp_data,
   output int                     mismatches,
   output int                     awaiting,
   output int                     results_checked,
   output int                     full_drops,
   output int                     empty_removes
);

   logic signed [bmhq_pkg::KEY_W-1:0]     heap_key     [HEAP_DEPTH];
   logic        [bmhq_pkg::PAYLOAD_W-1:0] heap_payload [HEAP_DEPTH];
   int                                    heap_fill;
   bmhq_pkg::rsp_item_type                expected_rsp_q [$];

   initial begin
      mismatches      = 0;
      awaiting        = 0;
      results_checked = 0;
      full_drops      = 0;
      empty_removes   = 0;
      heap_fill       = 0;
   end

   function automatic void swap_entries(input int a, input int b);
      logic signed [bmhq_pkg::KEY_W-1:0]     k;
      logic        [bmhq_pkg::PAYLOAD_W-1:0] p;
      k = heap_key[a];
      heap_key[a] = heap_key[b];
      heap_key[b] = k;
      p = heap_payload[a];
      heap_payload[a] = heap_payload[b];
      heap_payload[b] = p;
   endfunction

   // Update the heap copy for one request and return the result it must produce.
   function automatic bmhq_pkg::rsp_item_type serve_request(input bmhq_pkg::req_item_type req);
      bmhq_pkg::rsp_item_type r;
      int           pos;
      int           parent;
      int           best;
      int           lc;
      bit           settled;
      r = '0;
      r.status = bmhq_pkg::STATUS_OK;
      if (req.req_type == bmhq_pkg::REQ_INSERT) begin
         if (heap_fill >= HEAP_DEPTH) begin
            r.status = bmhq_pkg::STATUS_FULL;
         end else begin
            pos = heap_fill;
            heap_key[pos] = req.item_key;
            heap_payload[pos] = req.item_payload;
            settled = 1'b0;
            while (pos > 0 && !settled) begin
               parent = (pos - 1) / 2;
               if (heap_key[pos] < heap_key[parent]) begin
                  swap_entries(pos, parent);
                  pos = parent;
               end else begin
                  settled = 1'b1;
               end
            end
            heap_fill++;
         end
         r.out_key = heap_key[0];
         r.out_payload = heap_payload[0];
      end else if (heap_fill == 0) begin
         r.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
         r.out_key = heap_key[0];
         r.out_payload = heap_payload[0];
         heap_fill--;
         heap_key[0] = heap_key[heap_fill];
         heap_payload[0] = heap_payload[heap_fill];
         pos = 0;
         settled = 1'b0;
         while (!settled) begin
            best = pos;
            lc = 2 * pos + 1;
            if (lc < heap_fill && heap_key[lc] < heap_key[pos])
               best = lc;
            // right child wins only when strictly smaller than the current pick
            if (lc + 1 < heap_fill && heap_key[lc + 1] < heap_key[best])
               best = lc + 1;
            if (best == pos) begin
               settled = 1'b1;
            end else begin
               swap_entries(pos, best);
               pos = best;
            end
         end
      end
      r.item_count = bmhq_pkg::ITEM_COUNT_W'(heap_fill);
      return r;
   endfunction

   always @(posedge clock) begin
      bmhq_pkg::rsp_item_type want;
      bmhq_pkg::rsp_item_type got;
      if (reset) begin
         heap_fill = 0;
         expected_rsp_q.delete();
      end else begin
         // check the result before logging a new transfer: both can land on one edge
         if (rsp_valid) begin
            got = rsp_data;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with none expected: key %0d payload %h %s %0d %s %0d",
                           $realtime, got.out_key, got.out_payload, "count",
                           got.item_count, "status", got.status);
            end else begin
               want = expected_rsp_q.pop_front();
               results_checked++;
               if (got.out_key !== want.out_key || got.out_payload !== want.out_payload ||
                   got.item_count !== want.item_count || got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: result mismatch: expected key %0d payload %h count %0d ",
                            $realtime, want.out_key, want.out_payload, want.item_count);
                     $display("status %0d, got key %0d payload %h count %0d status %0d",
                              want.status, got.out_key, got.out_payload, got.item_count,
                              got.status);
                  end
               end
            end
         end
         if (start && !busy) begin
            want = serve_request(req_data);
            if (want.status == bmhq_pkg::STATUS_FULL)
               full_drops++;
            if (want.status == bmhq_pkg::STATUS_EMPTY)
               empty_removes++;
            expected_rsp_q.push_back(want);
         end
      end
      awaiting = expected_rsp_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Top of the min-heap queue testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module tb_top;

   localparam int HEAP_DEPTH = 64;
   // Longest correct quiet stretch: a full sender gap plus the longest remove.
   localparam int QUIET_LIMIT = 1000;
   localparam int MAX_GAP = 40;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   bmhq_pkg::req_item_type req_data  = '0;
   logic                   busy;
   logic                   rsp_valid;
   bmhq_pkg::rsp_item_type rsp_data;

   int mismatches;
   int awaiting;
   int results_checked;
   int full_drops;
   int empty_removes;
   int sender_idle_pct = 0;
   int requests_sent   = 0;

   binary_min_heap_queue_top #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   heap_order_checker #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatches     (mismatches),
      .awaiting       (awaiting),
      .results_checked(results_checked),
      .full_drops     (full_drops),
      .empty_removes  (empty_removes)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Keys cluster on a few small values to force ties, and hit the signed extremes.
   function automatic logic signed [bmhq_pkg::KEY_W-1:0] pick_key();
      logic signed [bmhq_pkg::KEY_W-1:0] k;
      int                                sel;
      sel = $urandom_range(99);
      if (sel < 30) begin
         k = $urandom_range(6);
         k = k - 3;
      end else if (sel < 40) begin
         case ($urandom_range(3))
            0:       k = 32'h7FFF_FFFF;
            1:       k = 32'h8000_0000;
            2:       k = 32'h0000_0000;
            default: k = 32'hFFFF_FFFF;
         endcase
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic issue(input bmhq_pkg::req_kind_type kind,
                        input logic signed [bmhq_pkg::KEY_W-1:0] key,
                        input logic [bmhq_pkg::PAYLOAD_W-1:0] payload);
      bmhq_pkg::req_item_type item;
      bmhq_pkg::req_item_type noise;
      int                     gap;
      item.req_type = kind;
      item.item_key = key;
      item.item_payload = payload;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
         noise.req_type = bmhq_pkg::req_kind_type'($urandom_range(1));
         noise.item_key = $urandom;
         noise.item_payload = $urandom;
         start <= 1'b0;
         req_data <= noise;
         @(negedge clock);
         gap++;
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic random_insert();
      issue(bmhq_pkg::REQ_INSERT, pick_key(), $urandom);
   endtask

   task automatic random_remove();
      // key and payload are don't-care on a remove; keep them moving anyway
      issue(bmhq_pkg::REQ_REMOVE, $urandom, $urandom);
   endtask

   task automatic run_phase(input int idle_pct);
      sender_idle_pct = idle_pct;
      repeat (HEAP_DEPTH + 3) random_insert();
      repeat (HEAP_DEPTH + 3) random_remove();
      repeat (100) begin
         if ($urandom_range(99) < 60) random_insert();
         else random_remove();
      end
      repeat (100) begin
         if ($urandom_range(99) < 40) random_insert();
         else random_remove();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty remove, signed extremes, equal keys
      issue(bmhq_pkg::REQ_REMOVE, 32'h1234_5678, 32'h9ABC_DEF0);
      issue(bmhq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      issue(bmhq_pkg::REQ_INSERT, 32'h8000_0000, 32'h0000_0000);
      issue(bmhq_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0001);
      issue(bmhq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0002);
      issue(bmhq_pkg::REQ_INSERT, 32'sd5, 32'h0000_00A0);
      issue(bmhq_pkg::REQ_INSERT, 32'sd5, 32'h0000_00B0);
      issue(bmhq_pkg::REQ_INSERT, 32'sd5, 32'h0000_00C0);
      issue(bmhq_pkg::REQ_INSERT, 32'h8000_0000, 32'h0000_0003);
      repeat (9) issue(bmhq_pkg::REQ_REMOVE, 32'h0, 32'h0);
      // after the first remove both children are equal and smaller: left is taken
      issue(bmhq_pkg::REQ_INSERT, 32'sd1, 32'h0000_0011);
      issue(bmhq_pkg::REQ_INSERT, 32'sd4, 32'h0000_0044);
      issue(bmhq_pkg::REQ_INSERT, 32'sd4, 32'h0000_0045);
      issue(bmhq_pkg::REQ_INSERT, 32'sd9, 32'h0000_0099);
      repeat (2) issue(bmhq_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      run_phase(33);
      run_phase(62);
      run_phase(0);

      start <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (30) @(negedge clock);

      $display("Sent %0d requests and checked %0d results, through full and empty heaps,",
               requests_sent, results_checked);
      $display("including %0d dropped inserts and %0d removes on an empty heap.",
               full_drops, empty_removes);
      if (mismatches == 0 && awaiting == 0) begin
         $display("PASS binary_min_heap_queue_top");
      end else begin
         $display("FAIL binary_min_heap_queue_top");
      end
      $finish;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("No transfer for %0d cycles", QUIET_LIMIT);
      $display("FAIL binary_min_heap_queue_top");
      $finish;
   end

endmodule
